@@ rtl/sphere_min_distance_point_placer_assert.svh @@
// Assertion macros for the sphere point placer RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef SPHERE_MIN_DISTANCE_POINT_PLACER_ASSERT_SVH
`define SPHERE_MIN_DISTANCE_POINT_PLACER_ASSERT_SVH
`ifndef ASSERT_OFF
`define SMDP_A_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
	else $error("assertion failed");
`define SMDP_A_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define SMDP_A_IMP(lbl, ck, rn, ante, cons)
`define SMDP_A_NXT(lbl, ck, rn, ante, cons)
`endif
`endif

@@ rtl/smdp_pkg.sv @@
// Shared types, constants and tables for the sphere point placer.
// Used by every module of the block; depends on nothing.
package smdp_pkg;

	localparam int MAX_POINTS = 256;
	localparam int IDX_W      = $clog2(MAX_POINTS);
	localparam int CNT_W      = 9;
	localparam int COORD_W    = 17;
	localparam int MUL_W      = 32;

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
	} point_t;

	typedef enum logic [1:0] {
		CFG_RADIUS  = 2'd0,
		CFG_SPACING = 2'd1,
		CFG_TARGET  = 2'd2
	} cfg_idx_t;

	localparam logic [14:0] ANG_FULL    = 15'd23040;
	localparam logic [14:0] ANG_QUARTER = 15'd5760;
	localparam logic [14:0] ANG_HALF    = 15'd11520;
	localparam logic [14:0] ANG_3Q      = 15'd17280;
	localparam logic [31:0] RAD_Q30     = 32'd292818;
	localparam logic [30:0] Q30_ONE     = 31'h4000_0000;

	localparam logic [63:0] RECIP_110 = (64'd1 << 32) / 64'd110;
	localparam logic [63:0] RECIP_72  = (64'd1 << 32) / 64'd72;
	localparam logic [63:0] RECIP_42  = (64'd1 << 32) / 64'd42;
	localparam logic [63:0] RECIP_20  = (64'd1 << 32) / 64'd20;
	localparam logic [63:0] RECIP_6   = (64'd1 << 32) / 64'd6;

	function automatic logic [6:0] div_const(input logic [2:0] j);
		case (j)
			3'd0:    return 7'd110;
			3'd1:    return 7'd72;
			3'd2:    return 7'd42;
			3'd3:    return 7'd20;
			default: return 7'd6;
		endcase
	endfunction

	function automatic logic [31:0] div_recip(input logic [2:0] j);
		case (j)
			3'd0:    return RECIP_110[31:0];
			3'd1:    return RECIP_72[31:0];
			3'd2:    return RECIP_42[31:0];
			3'd3:    return RECIP_20[31:0];
			default: return RECIP_6[31:0];
		endcase
	endfunction

endpackage

@@ rtl/smdp_mul.sv @@
// Shared unsigned multiplier with a registered product.
// Depends on smdp_pkg.
module smdp_mul (
	input  logic                             clk,
	input  logic [smdp_pkg::MUL_W-1:0]       a,
	input  logic [smdp_pkg::MUL_W-1:0]       b,
	output logic [2*smdp_pkg::MUL_W-1:0]     p
);
	import smdp_pkg::*;

	always_ff @(posedge clk) begin
		p <= a * b;
	end

endmodule

@@ rtl/smdp_pt_mem.sv @@
// Point store: one write port, one registered read port.
// Depends on smdp_pkg.
module smdp_pt_mem (
	input  logic                        clk,
	input  logic                        we,
	input  logic [smdp_pkg::IDX_W-1:0]  waddr,
	input  smdp_pkg::point_t            wdata,
	input  logic                        re,
	input  logic [smdp_pkg::IDX_W-1:0]  raddr,
	output smdp_pkg::point_t            rdata
);
	import smdp_pkg::*;

	point_t mem_q [MAX_POINTS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ rtl/sphere_min_distance_point_placer.sv @@
// Top level of the sphere point placer: sequencer around one shared multiplier.
// Depends on smdp_pkg, smdp_mul, smdp_pt_mem and the assertion header.
//
// channel | dir | handshake          | payload
// s_      | in  | s_tvalid/s_tready  | s_tdata: polar_angle, azimuth_angle
// m_      | out | m_tvalid/m_tready  | m_tdata: coordinates, count; m_tuser: flags
// cfg_    | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// Each item runs through the four sines, then the coordinates, then check and output,
// with a distance check for each stored point between check and output, up to 255
// stored points; the single multiplier sets the pace.
// s_tready is high only while idle; the result register lets the next item in
// before the previous result is taken. Reset clears the point count and loads
// register defaults; the store itself needs no clearing.
module sphere_min_distance_point_placer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // polar_angle[13:0], azimuth_angle[28:14], zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // pos_x[16:0], pos_y[33:17], pos_z[50:34],
	                               // point_count[59:51], zero pad
	output logic [1:0]  m_tuser,   // accepted[0], store_full[1]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [33:0] cfg_data
);
	import smdp_pkg::*;
	`include "sphere_min_distance_point_placer_assert.svh"

	typedef enum logic [4:0] {
		S_IDLE, S_ANG, S_T, S_T2, S_U0, S_M1, S_M2, S_M3, S_S, S_F,
		S_X1, S_X2, S_X3, S_Y2, S_Y3, S_Z2, S_CHK,
		S_DX, S_DY, S_DZ, S_DC, S_DONE
	} state_t;

	state_t state_q;
	logic [15:0] rad_q;
	logic [33:0] spc_q;
	logic [CNT_W-1:0] tgt_q;
	logic [CNT_W-1:0] count_q;
	logic [1:0] k_q;
	logic [2:0] j_q;
	logic [IDX_W-1:0] idx_q;
	logic full_q, ok_q;
	logic m_tvalid_q, out_acc_q, out_full_q;
	coord_t out_x_q, out_y_q, out_z_q;
	logic [CNT_W-1:0] out_cnt_q;

	logic [13:0] polar_q;
	logic [14:0] azim_q;
	logic [12:0] x_q;
	logic neg_q;
	logic [30:0] t_q;
	logic [31:0] t2_q;
	logic [30:0] u_q;
	logic [31:0] n_q;
	logic [15:0] mag_q [4];
	logic sgn_q [4];
	coord_t px_q, py_q, pz_q;
	logic [35:0] acc_q;

	logic [MUL_W-1:0] mul_a, mul_b;
	logic [2*MUL_W-1:0] mul_p;
	logic mem_we, mem_re;
	logic [IDX_W-1:0] mem_raddr;
	point_t mem_rdata;

	logic [14:0] ang_base, ang_r1, ang_c, ang_r2, ang_off;
	logic [1:0] quad;
	logic [12:0] qarg;
	logic [29:0] q0;
	logic [36:0] qd;
	logic [32:0] rem;
	logic [29:0] qfix;
	logic [30:0] u_next;
	logic [33:0] s_rnd;
	logic [18:0] s_mag;
	logic [15:0] mag16;
	logic [46:0] sum47;
	logic [31:0] sum32;
	logic [16:0] mag_xy, mag_z;
	logic [35:0] dsum;
	logic [CNT_W-1:0] tgt_sat;
	logic full_c, out_free, last_pt;

	function automatic logic [16:0] absdiff(input coord_t a, input coord_t b);
		logic signed [17:0] d;
		d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
		return d[17] ? 17'(-d) : d[16:0];
	endfunction

	function automatic coord_t apply_sign(input logic neg, input logic [16:0] m);
		return coord_t'(neg ? (17'd0 - m) : m);
	endfunction

	smdp_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));

	smdp_pt_mem u_mem (
		.clk(clk), .we(mem_we), .waddr(IDX_W'(count_q)), .wdata({px_q, py_q, pz_q}),
		.re(mem_re), .raddr(mem_raddr), .rdata(mem_rdata)
	);

	assign s_tready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tuser   = {out_full_q, out_acc_q};
	assign m_tdata   = {4'd0, out_cnt_q, out_z_q, out_y_q, out_x_q};

	always_comb begin
		ang_base = k_q[1] ? azim_q : {1'b0, polar_q};
		ang_r1   = (ang_base >= ANG_FULL) ? ang_base - ANG_FULL : ang_base;
		ang_c    = k_q[0] ? ang_r1 + ANG_QUARTER : ang_r1;
		ang_r2   = (ang_c >= ANG_FULL) ? ang_c - ANG_FULL : ang_c;
		if (ang_r2 >= ANG_3Q) begin
			quad = 2'd3;
			ang_off = ang_r2 - ANG_3Q;
		end else if (ang_r2 >= ANG_HALF) begin
			quad = 2'd2;
			ang_off = ang_r2 - ANG_HALF;
		end else if (ang_r2 >= ANG_QUARTER) begin
			quad = 2'd1;
			ang_off = ang_r2 - ANG_QUARTER;
		end else begin
			quad = 2'd0;
			ang_off = ang_r2;
		end
		qarg = quad[0] ? 13'(ANG_QUARTER - ang_off) : ang_off[12:0];
	end

	always_comb begin
		q0     = mul_p[61:32];
		qd     = 37'(q0) * 37'(div_const(j_q));
		rem    = 33'(n_q) - qd[32:0];
		qfix   = q0 + 30'(rem >= 33'(div_const(j_q)));
		u_next = Q30_ONE - 31'(qfix);
		s_rnd  = 34'(mul_p[62:30]) + 34'd16384;
		s_mag  = s_rnd[33:15];
		mag16  = (s_mag > 19'd32768) ? 16'h8000 : s_mag[15:0];
		sum47  = mul_p[46:0] + 47'(64'd1 << 29);
		mag_xy = sum47[46:30];
		sum32  = mul_p[31:0] + 32'd16384;
		mag_z  = sum32[31:15];
		dsum   = acc_q + 36'(mul_p[33:0]);
		tgt_sat = (32'(tgt_q) > 32'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : tgt_q;
		full_c  = (count_q >= tgt_sat);
		out_free = !m_tvalid_q || m_tready;
		last_pt = (32'(idx_q) + 32'd1 == 32'(count_q));
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_T: begin
				mul_a = 32'(x_q);
				mul_b = RAD_Q30;
			end
			S_T2: begin
				mul_a = mul_p[31:0];
				mul_b = mul_p[31:0];
			end
			S_U0: begin
				mul_a = mul_p[61:30];
				mul_b = 32'(Q30_ONE);
			end
			S_M1: begin
				mul_a = t2_q;
				mul_b = 32'(u_q);
			end
			S_M2: begin
				mul_a = mul_p[61:30];
				mul_b = div_recip(j_q);
			end
			S_S: begin
				mul_a = 32'(t_q);
				mul_b = 32'(u_q);
			end
			S_X1: begin
				mul_a = 32'(mag_q[0]);
				mul_b = 32'(mag_q[3]);
			end
			S_X2, S_Y2: begin
				mul_a = 32'(rad_q);
				mul_b = 32'(mul_p[30:0]);
			end
			S_X3: begin
				mul_a = 32'(mag_q[0]);
				mul_b = 32'(mag_q[2]);
			end
			S_Y3: begin
				mul_a = 32'(rad_q);
				mul_b = 32'(mag_q[1]);
			end
			S_DX: begin
				mul_a = 32'(absdiff(px_q, mem_rdata.x));
				mul_b = mul_a;
			end
			S_DY: begin
				mul_a = 32'(absdiff(py_q, mem_rdata.y));
				mul_b = mul_a;
			end
			S_DZ: begin
				mul_a = 32'(absdiff(pz_q, mem_rdata.z));
				mul_b = mul_a;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mem_we    = (state_q == S_DONE) && out_free && ok_q;
	assign mem_re    = ((state_q == S_CHK) && !full_c && (count_q != '0)) || (state_q == S_DZ);
	assign mem_raddr = (state_q == S_DZ) ? IDX_W'(idx_q + 1'b1) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			rad_q      <= 16'd1024;
			spc_q      <= '0;
			tgt_q      <= 9'd256;
			count_q    <= '0;
			k_q        <= '0;
			j_q        <= '0;
			idx_q      <= '0;
			full_q     <= 1'b0;
			ok_q       <= 1'b0;
			m_tvalid_q <= 1'b0;
			out_acc_q  <= 1'b0;
			out_full_q <= 1'b0;
			out_cnt_q  <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_RADIUS:  rad_q <= cfg_data[15:0];
					CFG_SPACING: spc_q <= cfg_data;
					CFG_TARGET:  tgt_q <= cfg_data[8:0];
					default: ;
				endcase
			end
			if (m_tvalid_q && m_tready && state_q != S_DONE) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						k_q <= '0;
						state_q <= S_ANG;
					end
				end
				S_ANG: state_q <= S_T;
				S_T:   state_q <= S_T2;
				S_T2:  state_q <= S_U0;
				S_U0: begin
					j_q <= '0;
					state_q <= S_M2;
				end
				S_M1: state_q <= S_M2;
				S_M2: state_q <= S_M3;
				S_M3: begin
					if (j_q == 3'd4) begin
						state_q <= S_S;
					end else begin
						j_q <= j_q + 3'd1;
						state_q <= S_M1;
					end
				end
				S_S: state_q <= S_F;
				S_F: begin
					if (k_q == 2'd3) begin
						state_q <= S_X1;
					end else begin
						k_q <= k_q + 2'd1;
						state_q <= S_ANG;
					end
				end
				S_X1: state_q <= S_X2;
				S_X2: state_q <= S_X3;
				S_X3: state_q <= S_Y2;
				S_Y2: state_q <= S_Y3;
				S_Y3: state_q <= S_Z2;
				S_Z2: state_q <= S_CHK;
				S_CHK: begin
					full_q <= full_c;
					idx_q  <= '0;
					ok_q   <= !full_c;
					if (full_c || count_q == '0) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_DX;
					end
				end
				S_DX: state_q <= S_DY;
				S_DY: state_q <= S_DZ;
				S_DZ: state_q <= S_DC;
				S_DC: begin
					if (dsum <= 36'(spc_q)) begin
						ok_q <= 1'b0;
						state_q <= S_DONE;
					end else if (last_pt) begin
						state_q <= S_DONE;
					end else begin
						idx_q <= idx_q + 1'b1;
						state_q <= S_DX;
					end
				end
				S_DONE: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						out_acc_q  <= ok_q;
						out_full_q <= full_q;
						out_cnt_q  <= ok_q ? count_q + 1'b1 : count_q;
						if (ok_q) begin
							count_q <= count_q + 1'b1;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && s_tvalid) begin
			polar_q <= s_tdata[13:0];
			azim_q  <= s_tdata[28:14];
		end
		if (state_q == S_ANG) begin
			x_q   <= qarg;
			neg_q <= quad[1];
		end
		if (state_q == S_T2) begin
			t_q <= mul_p[30:0];
		end
		if (state_q == S_U0) begin
			t2_q <= mul_p[61:30];
			u_q  <= Q30_ONE;
		end
		if (state_q == S_M2) begin
			n_q <= mul_p[61:30];
		end
		if (state_q == S_M3) begin
			u_q <= u_next;
		end
		if (state_q == S_F) begin
			mag_q[k_q] <= mag16;
			sgn_q[k_q] <= neg_q;
		end
		if (state_q == S_X3) begin
			px_q <= apply_sign(sgn_q[0] ^ sgn_q[3], mag_xy);
		end
		if (state_q == S_Y3) begin
			py_q <= apply_sign(sgn_q[0] ^ sgn_q[2], mag_xy);
		end
		if (state_q == S_Z2) begin
			pz_q <= apply_sign(sgn_q[1], mag_z);
		end
		if (state_q == S_DY) begin
			acc_q <= 36'(mul_p[33:0]);
		end
		if (state_q == S_DZ) begin
			acc_q <= dsum;
		end
		if (state_q == S_DONE && out_free) begin
			out_x_q <= px_q;
			out_y_q <= py_q;
			out_z_q <= pz_q;
		end
	end

	`SMDP_A_IMP(a_cnt_max, clk, arst_n, 1'b1, 32'(count_q) <= 32'(MAX_POINTS))
	`SMDP_A_IMP(a_acc_flags, clk, arst_n, m_tvalid_q && out_acc_q, !out_full_q && out_cnt_q != '0)
	`SMDP_A_NXT(a_cnt_step, clk, arst_n, mem_we, count_q == $past(count_q) + 1'b1)

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the sphere minimum-spacing point placer.
// Predicts every result from fixed-point trig and a software point store.
// Depends on smdp_pkg and the sphere_min_distance_point_placer RTL.
`timescale 1ns / 1ps
module tb_top;
	import smdp_pkg::*;

	typedef struct {
		logic [13:0] polar;
		logic [14:0] azim;
	} cand_t;

	typedef struct {
		logic       accepted;
		logic       full;
		coord_t     x;
		coord_t     y;
		coord_t     z;
		logic [8:0] count;
	} placement_t;

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [31:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [63:0] m_tdata;
	logic [1:0] m_tuser;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [33:0] cfg_data = '0;

	sphere_min_distance_point_placer dut (.*);

	always #5 clk = ~clk;

	cand_t      pending_cands[$];
	placement_t expected_places[$];
	int         errors = 0;
	int         idle_cycles = 0;
	bit         hold_send = 0;
	int         send_gap = 0;
	int         recv_gap = 0;

	logic [15:0] radius_q;
	logic [33:0] spacing_q;
	logic [8:0]  target_q;
	coord_t      pts_x[MAX_POINTS];
	coord_t      pts_y[MAX_POINTS];
	coord_t      pts_z[MAX_POINTS];
	int          pts_n;

	function automatic longint quad_sine(longint unsigned x);
		longint unsigned t, t2, u, s;
		longint unsigned dv[5];
		dv = '{110, 72, 42, 20, 6};
		t = x * 292818;
		t2 = (t * t) >> 30;
		u = 64'd1 << 30;
		for (int i = 0; i < 5; i++)
			u = (64'd1 << 30) - (((t2 * u) >> 30) / dv[i]);
		s = (t * u) >> 30;
		s = (s + (1 << 14)) >> 15;
		if (s > 32768) s = 32768;
		return s;
	endfunction

	function automatic longint fx_sine(longint unsigned a);
		longint unsigned q, r, m;
		a = a % 23040;
		q = a / 5760;
		r = a % 5760;
		m = quad_sine((q & 1) ? 5760 - r : r);
		return (q >= 2) ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint mag(longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic longint sq(longint a, longint b);
		return (a - b) * (a - b);
	endfunction

	function automatic placement_t place_candidate(cand_t c);
		placement_t p;
		longint sp, cp, sa, ca, m, px, py, pz, d2;
		longint unsigned tgt;
		bit ok;
		sp = fx_sine(c.polar);
		cp = fx_sine((c.polar % 23040) + 5760);
		sa = fx_sine(c.azim);
		ca = fx_sine((c.azim % 23040) + 5760);
		m = (longint'(radius_q) * (mag(sp) * mag(ca)) + (64'd1 << 29)) >>> 30;
		px = ((sp < 0) != (ca < 0)) ? -m : m;
		m = (longint'(radius_q) * (mag(sp) * mag(sa)) + (64'd1 << 29)) >>> 30;
		py = ((sp < 0) != (sa < 0)) ? -m : m;
		m = (longint'(radius_q) * mag(cp) + (1 << 14)) >>> 15;
		pz = (cp < 0) ? -m : m;
		tgt = (target_q > MAX_POINTS) ? MAX_POINTS : target_q;
		p.full = (pts_n >= tgt);
		ok = !p.full;
		for (int i = 0; ok && i < pts_n; i++) begin
			d2 = sq(px, pts_x[i]) + sq(py, pts_y[i]) + sq(pz, pts_z[i]);
			if (d2 <= longint'(spacing_q)) ok = 0;
		end
		if (ok && pts_n < MAX_POINTS) begin
			pts_x[pts_n] = coord_t'(px);
			pts_y[pts_n] = coord_t'(py);
			pts_z[pts_n] = coord_t'(pz);
			pts_n++;
		end else
			ok = 0;
		p.accepted = ok;
		p.x = coord_t'(px);
		p.y = coord_t'(py);
		p.z = coord_t'(pz);
		p.count = 9'(pts_n);
		return p;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 92) return $urandom_range(1, 4);
		return $urandom_range(10, 60);
	endfunction

	task automatic report(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		errors++;
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [33:0] val);
		@(posedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		case (idx)
			CFG_RADIUS:  radius_q = val[15:0];
			CFG_SPACING: spacing_q = val;
			CFG_TARGET:  target_q = val[8:0];
			default: ;
		endcase
	endtask

	task automatic drain();
		while (pending_cands.size() || expected_places.size() || s_tvalid)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic push_cand(logic [13:0] p, logic [14:0] a);
		cand_t c;
		c.polar = p;
		c.azim = a;
		pending_cands.push_back(c);
	endtask

	task automatic random_phase(int n, bit wide);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) == 0)
				push_cand(14'($urandom), 15'($urandom));
			else if (wide)
				push_cand(14'($urandom_range(0, 11520)), 15'($urandom_range(0, 23040)));
			else
				push_cand(14'($urandom_range(0, 16383)), 15'($urandom_range(0, 32767)));
		end
		drain();
	endtask

	// driver
	always @(posedge clk) begin
		cand_t c;
		if (s_tvalid && s_tready) begin
			expected_places.push_back(place_candidate(pending_cands.pop_front()));
			send_gap = pick_gap();
		end
		if (s_tvalid && !s_tready) begin
		end else if (send_gap > 0) begin
			send_gap--;
			s_tvalid <= 0;
		end else if (!(hold_send && expected_places.size() != 0) &&
			pending_cands.size() != 0) begin
			c = pending_cands[0];
			s_tvalid <= 1;
			s_tdata <= {3'b0, c.azim, c.polar};
		end else
			s_tvalid <= 0;
	end

	// monitor
	always @(posedge clk) begin
		placement_t w;
		if (m_tvalid && m_tready) begin
			if (expected_places.size() == 0) begin
				report("unexpected result item", 1, 0);
			end else begin
				w = expected_places.pop_front();
				if (m_tuser[0] !== w.accepted) report("accepted", m_tuser[0], w.accepted);
				if (m_tuser[1] !== w.full) report("store_full", m_tuser[1], w.full);
				if (m_tdata[16:0] !== w.x) report("pos_x", $signed(m_tdata[16:0]), w.x);
				if (m_tdata[33:17] !== w.y) report("pos_y", $signed(m_tdata[33:17]), w.y);
				if (m_tdata[50:34] !== w.z) report("pos_z", $signed(m_tdata[50:34]), w.z);
				if (m_tdata[59:51] !== w.count) report("point_count", m_tdata[59:51], w.count);
			end
			recv_gap = pick_gap();
		end
		if (recv_gap > 0) begin
			recv_gap--;
			m_tready <= 0;
		end else
			m_tready <= 1;
	end

	// watchdog
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		radius_q = 1024;
		spacing_q = 0;
		target_q = 256;
		pts_n = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		repeat (2) @(posedge clk);

		// directed: extremes and quadrant edges at reset settings
		push_cand(0, 0);
		push_cand(0, 0);
		push_cand(11520, 23040);
		push_cand(5760, 5760);
		push_cand(5760, 11520);
		push_cand(5760, 17280);
		push_cand(16383, 32767);
		push_cand(2880, 8640);
		push_cand(8640, 20000);
		push_cand(11519, 23039);
		drain();

		// hold each item until every earlier result is in
		hold_send = 1;
		push_cand(1000, 3000);
		push_cand(1000, 3000);
		push_cand(7000, 12000);
		push_cand(2000, 21000);
		drain();
		hold_send = 0;

		write_reg(CFG_RADIUS, 65535);
		write_reg(CFG_SPACING, 34'h3FFFFFFFF);
		write_reg(CFG_TARGET, 0);
		push_cand(5760, 0);
		push_cand(0, 0);
		drain();
		write_reg(CFG_TARGET, 511);
		push_cand(5760, 2880);
		push_cand(4000, 100);
		push_cand(11520, 0);
		drain();
		write_reg(CFG_SPACING, 0);
		write_reg(CFG_RADIUS, 0);
		push_cand(3000, 7000);
		push_cand(3000, 7000);
		drain();
		write_reg(CFG_RADIUS, 65535);
		write_reg(CFG_TARGET, 3);
		random_phase(8, 1);

		write_reg(CFG_TARGET, 1);
		random_phase(60, 1);
		write_reg(CFG_TARGET, 60);
		write_reg(CFG_RADIUS, 1024);
		write_reg(CFG_SPACING, 150000);
		random_phase(350, 1);
		write_reg(CFG_SPACING, 400);
		write_reg(CFG_TARGET, 256);
		random_phase(500, 0);
		write_reg(CFG_RADIUS, 300);
		write_reg(CFG_SPACING, 34'h3FFFFFFFF);
		random_phase(100, 1);
		write_reg(CFG_SPACING, 5);
		random_phase(300, 1);

		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
